[rtl/core/bms_pkg.sv]
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and field widths for the balanced multi-stack unit.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned PartFieldW = 2;
  localparam int unsigned DataFieldW = 32;
  localparam int unsigned StatFieldW = 2;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [StatFieldW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

[rtl/core/bms_pick.sv]
// ----------------------------------------------------------------------------
// bms_pick
// Finds the least-filled and the most-filled partition, lowest index on ties.
// ----------------------------------------------------------------------------
module bms_pick #(
  parameter int unsigned NUM_PARTS  = 4,
  parameter int unsigned PART_DEPTH = 16
) (
  input  logic [NUM_PARTS-1:0][$clog2(PART_DEPTH+1)-1:0] count_i,
  output logic [$clog2(NUM_PARTS)-1:0]                   least_idx_o,
  output logic [$clog2(PART_DEPTH+1)-1:0]                least_cnt_o,
  output logic [$clog2(NUM_PARTS)-1:0]                   most_idx_o,
  output logic [$clog2(PART_DEPTH+1)-1:0]                most_cnt_o
);

  localparam int unsigned IdxW = $clog2(NUM_PARTS);
  localparam int unsigned CntW = $clog2(PART_DEPTH+1);

  logic [IdxW-1:0] lo_idx, hi_idx;
  logic [CntW-1:0] lo_cnt, hi_cnt;

  // strict compares keep the lowest index on equal counts
  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    lo_cnt = count_i[0];
    hi_cnt = count_i[0];
    for (int unsigned p = 1; p < NUM_PARTS; p++) begin
      if (count_i[p] < lo_cnt) begin
        lo_cnt = count_i[p];
        lo_idx = IdxW'(p);
      end
      if (count_i[p] > hi_cnt) begin
        hi_cnt = count_i[p];
        hi_idx = IdxW'(p);
      end
    end
  end

  assign least_idx_o = lo_idx;
  assign least_cnt_o = lo_cnt;
  assign most_idx_o  = hi_idx;
  assign most_cnt_o  = hi_cnt;

endmodule

[rtl/core/balanced_multi_stack_unit.sv]
// ----------------------------------------------------------------------------
// balanced_multi_stack_unit
// NUM_PARTS stacks sharing one store; push to least-filled, pop from most-filled.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while in_stall_o is low and returns
// its result in the cycle after acceptance. The partition choice and the
// fill-count update are done in the cycle of acceptance; the single registered
// read port of the shared store supplies the popped data. A push when every
// partition is full returns status full, a pop when all are empty returns
// status empty; both report partition 0 with zero data and leave the stacks
// untouched. in_stall_o is raised only while a result is held by out_stall_i.
module balanced_multi_stack_unit
  import bms_pkg::*;
#(
  parameter int unsigned NUM_PARTS  = 4,
  parameter int unsigned PART_DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic signed [31:0]    value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            partition_o,
  output logic signed [31:0]    data_out_o,
  output logic [1:0]            status_o
);

  localparam int unsigned IdxW   = $clog2(NUM_PARTS);
  localparam int unsigned CntW   = $clog2(PART_DEPTH+1);
  localparam int unsigned Words  = NUM_PARTS * PART_DEPTH;
  localparam int unsigned AddrW  = $clog2(Words);
  localparam int unsigned ExtW   = (DATA_WIDTH > DataFieldW) ? DATA_WIDTH : DataFieldW;

  logic [NUM_PARTS-1:0][CntW-1:0] cnt_q;
  logic [IdxW-1:0]                least_idx, most_idx;
  logic [CntW-1:0]                least_cnt, most_cnt;

  logic [DATA_WIDTH-1:0] mem [Words];

  logic                  s1_valid_q;
  logic [IdxW-1:0]       s1_part_q;
  status_e               s1_status_q;
  op_e                   s1_op_q;
  logic [DATA_WIDTH-1:0] s1_wdata_q;
  logic [DATA_WIDTH-1:0] rd_q;

  logic                  advance, accept;
  op_e                   op;
  logic                  push_ok, pop_ok;
  logic [AddrW-1:0]      push_addr, pop_addr;
  logic [ExtW-1:0]       val_ext;
  logic [DATA_WIDTH-1:0] wdata;
  status_e               status_d;
  logic [IdxW-1:0]       part_d;
  logic [ExtW-1:0]       out_ext;

  bms_pick #(
    .NUM_PARTS  (NUM_PARTS),
    .PART_DEPTH (PART_DEPTH)
  ) u_pick (
    .count_i     (cnt_q),
    .least_idx_o (least_idx),
    .least_cnt_o (least_cnt),
    .most_idx_o  (most_idx),
    .most_cnt_o  (most_cnt)
  );

  assign advance    = !s1_valid_q || !out_stall_i;
  assign accept     = in_valid_i && advance;
  assign in_stall_o = !advance;

  assign op      = op_e'(operation_i);
  assign push_ok = (op == OP_PUSH) && (least_cnt < CntW'(PART_DEPTH));
  assign pop_ok  = (op == OP_POP) && (most_cnt != '0);

  assign push_addr = AddrW'(least_idx) * AddrW'(PART_DEPTH) + AddrW'(least_cnt);
  assign pop_addr  = AddrW'(most_idx) * AddrW'(PART_DEPTH) + AddrW'(most_cnt - CntW'(1));

  assign val_ext = ExtW'(unsigned'(value_i));
  assign wdata   = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    status_d = ST_OK;
    part_d   = '0;
    case (op)
      OP_PUSH: begin
        if (push_ok) begin
          part_d = least_idx;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_POP: begin
        if (pop_ok) begin
          part_d = most_idx;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // fill counts move at acceptance so the next transaction sees them at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      if (push_ok) begin
        cnt_q[least_idx] <= least_cnt + CntW'(1);
      end else if (pop_ok) begin
        cnt_q[most_idx] <= most_cnt - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && push_ok) begin
      mem[push_addr] <= wdata;
    end
  end

  // hold the read data while the result waits
  always_ff @(posedge clk_i) begin
    if (accept && pop_ok) begin
      rd_q <= mem[pop_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_part_q   <= part_d;
      s1_status_q <= status_d;
      s1_op_q     <= op;
      s1_wdata_q  <= wdata;
    end
  end

  always_comb begin
    out_ext = '0;
    if (s1_status_q == ST_OK) begin
      if (s1_op_q == OP_POP) begin
        out_ext = ExtW'(rd_q);
      end else begin
        out_ext = ExtW'(s1_wdata_q);
      end
    end
  end

  assign out_valid_o = s1_valid_q;
  assign partition_o = PartFieldW'(s1_part_q);
  assign data_out_o  = signed'(out_ext[DataFieldW-1:0]);
  assign status_o    = s1_status_q;

endmodule
